/* rtl/sprd_pkg.sv */
// Shared types and constants for the sign pattern run detector.
// No dependencies; imported by sign_pattern_run_detector_top.
`default_nettype none

package sprd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CMD_W     = 3;
    localparam int VERDICT_W = 2;
    localparam int LIMIT_W   = 16;
    localparam int RUN_W     = 17;
    localparam int COUNT_W   = 4;
    localparam int SHIFT_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESTART        = 3'd0,
        CMD_SIX_PRESENT    = 3'd1,
        CMD_SIX_ABSENT     = 3'd2,
        CMD_TWELVE_PRESENT = 3'd3,
        CMD_TWELVE_ABSENT  = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESENT_SAMPLES = 1'b0,
        CFG_ABSENT_SAMPLES  = 1'b1
    } cfg_idx_t;

    // group sizes in samples
    localparam logic [COUNT_W:0] GROUP_SIX    = 5'd6;
    localparam logic [COUNT_W:0] GROUP_TWELVE = 5'd12;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;

    localparam logic [RUN_W-1:0] RUN_MAX = 17'h1FFFF;

    // sign patterns, newest sign in bit 0
    localparam logic [SHIFT_W-1:0] PAT_SIX_POS    = 16'h0038;
    localparam logic [SHIFT_W-1:0] PAT_SIX_NEG    = 16'h0007;
    localparam logic [SHIFT_W-1:0] PAT_TWELVE_POS = 16'h0CCC;
    localparam logic [SHIFT_W-1:0] PAT_TWELVE_NEG = 16'h0333;

    localparam logic [VERDICT_W-1:0] VERDICT_NONE    = 2'b00;
    localparam logic [VERDICT_W-1:0] VERDICT_PRESENT = 2'b01;
    localparam logic [VERDICT_W-1:0] VERDICT_ABSENT  = 2'b11;

    // reciprocal of 6 scaled by 2^18; exact floor for any 16-bit value
    localparam logic [16:0] RECIP_SIX = 17'd43691;
    localparam int RECIP_SHIFT = 18;

endpackage

`default_nettype wire

/* rtl/sign_pattern_run_detector_top.sv */
// Sign pattern run detector: input register, group/run update, result register.
// Depends on sprd_pkg.
//
//  channel | signals                            | beat accepted when
//  --------+------------------------------------+---------------------------
//  in      | in_valid, in_ready, command, sample| in_valid && in_ready
//  out     | out_valid, out_ready, verdict      | out_valid && out_ready
//  cfg     | cfg_wr_en, cfg_index, cfg_data     | cfg_wr_en (no stall)
//
// One beat per cycle sustained while the out channel is not stalled; each beat passes
// through the input register, then the result register. All detector state updates
// happen as a beat moves from the input register into the result register.
// Reset clears the valid bits, counters, sign register, polarity and limits.
// A stalled out channel holds the result; in_ready drops only when both
// registers are full.
`default_nettype none

module sign_pattern_run_detector_top
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [sprd_pkg::CMD_W-1:0]          command,
    input  wire logic signed [sprd_pkg::SAMPLE_W-1:0] sample,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [sprd_pkg::VERDICT_W-1:0]    verdict,
    input  wire logic                                cfg_wr_en,
    input  wire logic [sprd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sprd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sprd_pkg::*;

    // configured counts, kept already rounded down to multiples of 6 and 12
    logic [LIMIT_W-1:0] present6_reg, present12_reg, absent6_reg, absent12_reg;

    logic [32:0]        recip_prod;
    logic [14:0]        q6;
    logic [13:0]        q12;
    logic [LIMIT_W-1:0] round6, round12;

    assign recip_prod = {1'b0, cfg_data} * {16'b0, RECIP_SIX};
    assign q6         = recip_prod[32:RECIP_SHIFT];
    assign q12        = q6[14:1];
    assign round6     = LIMIT_W'({q6, 2'b00} + {1'b0, q6, 1'b0});
    assign round12    = LIMIT_W'({q12, 3'b000} + {1'b0, q12, 2'b00});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present6_reg  <= '0;
            present12_reg <= '0;
            absent6_reg   <= '0;
            absent12_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PRESENT_SAMPLES:
                begin
                    present6_reg  <= round6;
                    present12_reg <= round12;
                end
                CFG_ABSENT_SAMPLES:
                begin
                    absent6_reg  <= round6;
                    absent12_reg <= round12;
                end
                default:
                begin
                    present6_reg <= present6_reg;
                end
            endcase
        end
    end

    // pipeline handshake
    logic                       s1_valid_reg;
    logic [CMD_W-1:0]           s1_command_reg;
    logic                       s1_positive_reg;
    logic                       out_valid_reg;
    logic [VERDICT_W-1:0]       verdict_reg, verdict_next;
    logic                       s2_free;
    logic                       advance;

    assign s2_free   = !out_valid_reg || out_ready;
    assign advance   = s1_valid_reg && s2_free;
    assign in_ready  = !s1_valid_reg || s2_free;
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_command_reg  <= command;
            s1_positive_reg <= !sample[SAMPLE_W-1] && (sample != '0);
        end
        if (advance)
            verdict_reg <= verdict_next;
    end

    // detector state
    logic [COUNT_W-1:0] group_count_reg, group_count_next;
    logic [SHIFT_W-1:0] sign_shift_reg, sign_shift_next;
    logic [RUN_W-1:0]   positive_run_reg, positive_run_next;
    logic [RUN_W-1:0]   negative_run_reg, negative_run_next;
    logic [RUN_W-1:0]   absent_run_reg, absent_run_next;
    logic               polarity_neg_reg, polarity_neg_next;
    logic [LIMIT_W-1:0] limits_reg [4];
    logic [LIMIT_W-1:0] limits_next [4];

    logic [SHIFT_W-1:0] shifted;
    logic [COUNT_W:0]   count_inc;
    logic [COUNT_W:0]   step;
    logic [RUN_W-1:0]   step_run;
    logic               twelve;
    logic               is_detect;
    logic [SHIFT_W-1:0] pat_pos, pat_neg, pat_absent;
    logic [LIMIT_W-1:0] lim_present, lim_absent;
    logic [RUN_W:0]     pos_sum, neg_sum, abs_sum;
    logic [RUN_W-1:0]   pos_adv, neg_adv, abs_adv;

    assign twelve    = (s1_command_reg == CMD_TWELVE_PRESENT)
                    || (s1_command_reg == CMD_TWELVE_ABSENT);
    assign is_detect = (s1_command_reg == CMD_SIX_PRESENT)
                    || (s1_command_reg == CMD_SIX_ABSENT) || twelve;
    assign step      = twelve ? GROUP_TWELVE : GROUP_SIX;
    assign step_run  = RUN_W'(step);
    assign shifted   = {sign_shift_reg[SHIFT_W-2:0], s1_positive_reg};
    assign count_inc = {1'b0, group_count_reg} + 1'b1;

    assign pat_pos     = twelve ? PAT_TWELVE_POS : PAT_SIX_POS;
    assign pat_neg     = twelve ? PAT_TWELVE_NEG : PAT_SIX_NEG;
    assign pat_absent  = polarity_neg_reg ? pat_pos : pat_neg;
    assign lim_present = twelve ? limits_reg[2] : limits_reg[0];
    assign lim_absent  = twelve ? limits_reg[3] : limits_reg[1];

    // saturating run advance
    assign pos_sum = {1'b0, positive_run_reg} + {1'b0, step_run};
    assign neg_sum = {1'b0, negative_run_reg} + {1'b0, step_run};
    assign abs_sum = {1'b0, absent_run_reg} + {1'b0, step_run};
    assign pos_adv = pos_sum[RUN_W] ? RUN_MAX : pos_sum[RUN_W-1:0];
    assign neg_adv = neg_sum[RUN_W] ? RUN_MAX : neg_sum[RUN_W-1:0];
    assign abs_adv = abs_sum[RUN_W] ? RUN_MAX : abs_sum[RUN_W-1:0];

    always_comb
    begin
        group_count_next  = group_count_reg;
        sign_shift_next   = sign_shift_reg;
        positive_run_next = positive_run_reg;
        negative_run_next = negative_run_reg;
        absent_run_next   = absent_run_reg;
        polarity_neg_next = polarity_neg_reg;
        limits_next       = limits_reg;
        verdict_next      = VERDICT_NONE;

        if (s1_command_reg == CMD_RESTART)
        begin
            group_count_next  = '0;
            sign_shift_next   = '0;
            positive_run_next = '0;
            negative_run_next = '0;
            absent_run_next   = '0;
            polarity_neg_next = 1'b0;
            limits_next[0]    = present6_reg;
            limits_next[1]    = absent6_reg;
            limits_next[2]    = present12_reg;
            limits_next[3]    = absent12_reg;
        end
        else if (is_detect)
        begin
            if (count_inc != step)
            begin
                sign_shift_next  = shifted;
                group_count_next = count_inc[COUNT_W] ? COUNT_MAX : count_inc[COUNT_W-1:0];
            end
            else
            begin
                // group complete: match, update run, then clear for next group
                group_count_next = '0;
                sign_shift_next  = '0;
                case (s1_command_reg)
                    CMD_SIX_PRESENT, CMD_TWELVE_PRESENT:
                    begin
                        if (shifted == pat_pos)
                        begin
                            negative_run_next = '0;
                            positive_run_next = pos_adv;
                            if (pos_adv == {1'b0, lim_present})
                            begin
                                polarity_neg_next = 1'b0;
                                verdict_next      = VERDICT_PRESENT;
                            end
                        end
                        else if (shifted == pat_neg)
                        begin
                            positive_run_next = '0;
                            negative_run_next = neg_adv;
                            if (neg_adv == {1'b0, lim_present})
                            begin
                                polarity_neg_next = 1'b1;
                                verdict_next      = VERDICT_PRESENT;
                            end
                        end
                        else
                        begin
                            positive_run_next = '0;
                            negative_run_next = '0;
                        end
                    end
                    CMD_SIX_ABSENT, CMD_TWELVE_ABSENT:
                    begin
                        if (shifted == pat_absent)
                        begin
                            absent_run_next = abs_adv;
                            if (abs_adv == {1'b0, lim_absent})
                                verdict_next = VERDICT_ABSENT;
                        end
                        else
                        begin
                            absent_run_next = '0;
                        end
                    end
                    default:
                    begin
                        verdict_next = VERDICT_NONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg  <= '0;
            sign_shift_reg   <= '0;
            positive_run_reg <= '0;
            negative_run_reg <= '0;
            absent_run_reg   <= '0;
            polarity_neg_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                limits_reg[i] <= '0;
        end
        else if (advance)
        begin
            group_count_reg  <= group_count_next;
            sign_shift_reg   <= sign_shift_next;
            positive_run_reg <= positive_run_next;
            negative_run_reg <= negative_run_next;
            absent_run_reg   <= absent_run_next;
            polarity_neg_reg <= polarity_neg_next;
            limits_reg       <= limits_next;
        end
    end

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (verdict_reg != 2'b10))
        else $error("verdict outside -1..1");

    assert property (@(posedge clk) disable iff (!rst_n)
        !((positive_run_reg != '0) && (negative_run_reg != '0)))
        else $error("positive and negative runs both active");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_command_reg == CMD_RESTART)) |=>
            (positive_run_reg == '0) && (absent_run_reg == '0)
            && !polarity_neg_reg && (group_count_reg == '0))
        else $error("restart did not clear detector state");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(verdict_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire
